[hw/rtl/icph_pkg.sv]
package icph_pkg;

    localparam int WORD_W  = 16;
    localparam int MODE_W  = 2;
    localparam int INDEX_W = 3;

    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [MODE_W-1:0]  mode_t;
    typedef logic [INDEX_W-1:0] index_t;

    // register indexes on the configuration port
    localparam index_t REG_HEADER_MODE      = 3'd0;
    localparam index_t REG_LOCAL_IP_FIRST   = 3'd1;
    localparam index_t REG_LOCAL_IP_SECOND  = 3'd2;
    localparam index_t REG_REMOTE_IP_FIRST  = 3'd3;
    localparam index_t REG_REMOTE_IP_SECOND = 3'd4;

    // header modes; both bits set decodes as TCP
    localparam mode_t MODE_NONE = 2'd0;
    localparam mode_t MODE_TCP  = 2'd1;
    localparam mode_t MODE_UDP  = 2'd2;
    localparam mode_t MODE_BOTH = 2'd3;

    localparam word_t PROTO_TCP = 16'd6;
    localparam word_t PROTO_UDP = 16'd17;

    localparam mode_t RST_HEADER_MODE      = MODE_NONE;
    localparam word_t RST_LOCAL_IP_FIRST   = 16'd43200;
    localparam word_t RST_LOCAL_IP_SECOND  = 16'd58881;
    localparam word_t RST_REMOTE_IP_FIRST  = 16'd43200;
    localparam word_t RST_REMOTE_IP_SECOND = 16'd3585;

    function automatic word_t swap16(input word_t v);
        return {v[7:0], v[15:8]};
    endfunction

    // one end-around fold of a 17-bit sum
    function automatic word_t fold17(input logic [WORD_W:0] s);
        logic [WORD_W:0] t;
        t = {1'b0, s[WORD_W-1:0]} + {{WORD_W{1'b0}}, s[WORD_W]};
        return t[WORD_W-1:0];
    endfunction

endpackage

[hw/rtl/internet_checksum_pseudo_header.sv]
// Two register stages, input and result: a request taken into the input register
//   reaches the result register and m_tvalid once that register is free.
// Throughput: one word per cycle, a last word waiting while a checksum is unread; the
//   sum feedback is one 16-bit end-around add. Reset (rst_n low, asynchronous):
//   both stages empty, sum and count cleared, configuration registers to defaults.
module internet_checksum_pseudo_header
(
    input  logic                 clk,
    input  logic                 rst_n,
    // config write port
    input  logic                 cfg_wen,
    input  icph_pkg::index_t     cfg_addr,
    input  icph_pkg::word_t      cfg_wdata,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // [15:0] data_word
    input  logic                 s_tlast,   // last_word
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata    // [15:0] checksum
);
    import icph_pkg::*;

    // configuration
    mode_t header_mode_reg;
    word_t local_ip_first_reg;
    word_t local_ip_second_reg;
    word_t remote_ip_first_reg;
    word_t remote_ip_second_reg;

    // input stage
    logic  in_valid_reg;
    word_t in_word_reg;
    logic  in_last_reg;

    // accumulator
    word_t sum_reg;
    word_t count_reg;

    // result stage
    logic  out_valid_reg;
    word_t checksum_reg;

    logic  out_free;
    logic  advance;

    word_t sum_next;
    word_t count_next;
    word_t length_bytes;
    word_t proto_word;
    logic  header_on;
    logic  is_tcp;
    logic [WORD_W+2:0] wide_sum;
    logic [WORD_W:0]   fold_once;
    word_t final_sum;

    // ---------------------------------------------------------------
    // Configuration writes; indexes past the list are dropped.
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_mode_reg      <= RST_HEADER_MODE;
            local_ip_first_reg   <= RST_LOCAL_IP_FIRST;
            local_ip_second_reg  <= RST_LOCAL_IP_SECOND;
            remote_ip_first_reg  <= RST_REMOTE_IP_FIRST;
            remote_ip_second_reg <= RST_REMOTE_IP_SECOND;
        end
        else if (cfg_wen)
        begin
            case (cfg_addr)
                REG_HEADER_MODE:      header_mode_reg      <= cfg_wdata[MODE_W-1:0];
                REG_LOCAL_IP_FIRST:   local_ip_first_reg   <= cfg_wdata;
                REG_LOCAL_IP_SECOND:  local_ip_second_reg  <= cfg_wdata;
                REG_REMOTE_IP_FIRST:  remote_ip_first_reg  <= cfg_wdata;
                REG_REMOTE_IP_SECOND: remote_ip_second_reg <= cfg_wdata;
                default:              ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Flow control. A non-last word only touches the accumulator, so it
    // moves on even while a checksum waits; a last word needs the result
    // register free (empty or being taken this cycle).
    // ---------------------------------------------------------------
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_word_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // ---------------------------------------------------------------
    // Datapath.
    // Running word: one end-around add into the sum.
    // Last word: sum, word and, unless the mode is none, the six header words
    // go through one plain add, then two folds. Ones' complement sums are the
    // same whether the carry goes around at each add or once at the end.
    // ---------------------------------------------------------------
    assign sum_next   = fold17({1'b0, sum_reg} + {1'b0, in_word_reg});
    assign count_next = count_reg + 16'd1;

    assign header_on    = (header_mode_reg != MODE_NONE);
    assign is_tcp       = header_mode_reg inside {MODE_TCP, MODE_BOTH};
    assign length_bytes = swap16({count_next[WORD_W-2:0], 1'b0});
    assign proto_word   = swap16(is_tcp ? PROTO_TCP : PROTO_UDP);

    always_comb
    begin
        wide_sum = {3'b000, sum_reg} + {3'b000, in_word_reg};
        if (header_on)
        begin
            wide_sum = wide_sum
                     + {3'b000, local_ip_first_reg}  + {3'b000, local_ip_second_reg}
                     + {3'b000, remote_ip_first_reg} + {3'b000, remote_ip_second_reg}
                     + {3'b000, length_bytes}        + {3'b000, proto_word};
        end
        fold_once = {1'b0, wide_sum[WORD_W-1:0]} + {{(WORD_W-2){1'b0}}, wide_sum[WORD_W+2:WORD_W]};
        final_sum = fold17(fold_once);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else if (advance)
        begin
            if (in_last_reg)
            begin
                sum_reg   <= '0;
                count_reg <= '0;
            end
            else
            begin
                sum_reg   <= sum_next;
                count_reg <= count_next;
            end
        end
    end

    // ---------------------------------------------------------------
    // Result register.
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            checksum_reg <= ~final_sum;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = checksum_reg;

endmodule

[hw/rtl/icph_checker.sv]
module icph_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // stalled checksum holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("checksum changed while stalled");

    // result register is empty once reset has been seen
    assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("result valid during reset");

    // a new checksum only comes from a word that just left the input stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tready))
        else $error("checksum appeared without input stage moving");

    // a last word taken behind a stalled checksum blocks input until it drains
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready && s_tvalid && s_tready && s_tlast
        |=> !s_tready || m_tready)
        else $error("input taken past a pending last word");

endmodule

bind internet_checksum_pseudo_header icph_checker u_icph_checker (.*);

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
    import icph_pkg::*;

    // Checksum predictor plus the queue of checksums still owed by the block.
    class checksum_scoreboard;
        mode_t  hdr_mode;
        word_t  local_first;
        word_t  local_second;
        word_t  remote_first;
        word_t  remote_second;
        word_t  partial_sum;
        word_t  word_total;
        word_t  checksum_q[$];
        int     failures;
        int     words_seen;
        int     checksums_seen;
        int     reg_writes;

        function new();
            hdr_mode      = RST_HEADER_MODE;
            local_first   = RST_LOCAL_IP_FIRST;
            local_second  = RST_LOCAL_IP_SECOND;
            remote_first  = RST_REMOTE_IP_FIRST;
            remote_second = RST_REMOTE_IP_SECOND;
            partial_sum   = '0;
            word_total    = '0;
            failures      = 0;
            words_seen    = 0;
            checksums_seen = 0;
            reg_writes    = 0;
        endfunction

        // 16-bit ones' complement add, carry folded back in
        static function word_t ones_add(word_t a, word_t b);
            logic [WORD_W:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[WORD_W-1:0] + word_t'(s[WORD_W]);
        endfunction

        function void write_reg(index_t idx, word_t val);
            reg_writes++;
            case (idx)
                REG_HEADER_MODE:      hdr_mode      = val[MODE_W-1:0];
                REG_LOCAL_IP_FIRST:   local_first   = val;
                REG_LOCAL_IP_SECOND:  local_second  = val;
                REG_REMOTE_IP_FIRST:  remote_first  = val;
                REG_REMOTE_IP_SECOND: remote_second = val;
                default: ;
            endcase
        endfunction

        function void note_request(word_t data, logic last);
            word_t sum;
            word_t byte_len;
            word_t proto;
            words_seen++;
            sum        = ones_add(partial_sum, data);
            word_total = word_total + 1'b1;
            if (!last)
            begin
                partial_sum = sum;
                return;
            end
            if (hdr_mode != MODE_NONE)
            begin
                // both mode bits set decodes as TCP
                proto    = (hdr_mode == MODE_UDP) ? PROTO_UDP : PROTO_TCP;
                byte_len = {word_total[WORD_W-2:0], 1'b0};
                sum = ones_add(sum, local_first);
                sum = ones_add(sum, local_second);
                sum = ones_add(sum, remote_first);
                sum = ones_add(sum, remote_second);
                sum = ones_add(sum, {byte_len[7:0], byte_len[15:8]});
                sum = ones_add(sum, {proto[7:0], proto[15:8]});
            end
            checksum_q.push_back(~sum);
            partial_sum = '0;
            word_total  = '0;
        endfunction

        function void check_result(word_t got);
            word_t want;
            if (checksum_q.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("%0t: checksum %h arrived with none outstanding", $realtime, got);
                return;
            end
            want = checksum_q.pop_front();
            checksums_seen++;
            if (got !== want)
            begin
                failures++;
                if (failures <= 10)
                    $display("%0t: checksum expected %h got %h", $realtime, want, got);
            end
        endfunction

        function int outstanding();
            return checksum_q.size();
        endfunction

        function void flush_check();
            if (checksum_q.size() != 0)
            begin
                failures += checksum_q.size();
                $display("%0d checksums never arrived", checksum_q.size());
            end
        endfunction
    endclass

    localparam int STALL_LIMIT = 5000;   // cycles with no handshake on either side
    localparam int HOLD_CYCLES = 300;    // long receiver hold-off

    logic    clk;
    logic    rst_n;
    logic    cfg_wen;
    index_t  cfg_addr;
    word_t   cfg_wdata;
    logic    s_tvalid;
    logic    s_tready;
    logic [15:0] s_tdata;   // [15:0] data_word
    logic    s_tlast;       // last_word
    logic    m_tvalid;
    logic    m_tready;
    logic [15:0] m_tdata;   // [15:0] checksum

    checksum_scoreboard sb;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int rx_hold_left = 0;
    int stall_cycles = 0;

    internet_checksum_pseudo_header dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: random stalls at rx_idle_pct, or a counted hold-off when one
    // is requested. Hold-offs are only armed right after a rising edge, so
    // there is no race with this falling-edge update.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_left > 0)
            begin
                m_tready <= 1'b0;
                rx_hold_left--;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Monitor: both handshakes sampled at the rising edge, pre-update values.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_request(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    // Watchdog: ends the run if neither side moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // One request; returns right after the edge that accepted it. tvalid stays
    // high until the next call (or settle) decides at the falling edge.
    task automatic send_word(input word_t data, input logic last);
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Drop tvalid, wait for every owed checksum, then give the two register
    // stages time to empty before anything touches the configuration.
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input index_t idx, input word_t val);
        @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_wen   <= 1'b0;
    endtask

    // mode value with random junk above the mode bits
    function automatic word_t mode_word(input mode_t mode);
        word_t v;
        v = word_t'($urandom);
        v[MODE_W-1:0] = mode;
        return v;
    endfunction

    // data skewed toward the all-zero and all-one extremes
    function automatic word_t pick_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return word_t'($urandom);
        endcase
    endfunction

    function automatic word_t pick_addr();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return word_t'($urandom);
        endcase
    endfunction

    task automatic reconfigure();
        settle();
        write_reg(REG_HEADER_MODE, mode_word(mode_t'($urandom_range(0, 3))));
        write_reg(REG_LOCAL_IP_FIRST, pick_addr());
        write_reg(REG_LOCAL_IP_SECOND, pick_addr());
        write_reg(REG_REMOTE_IP_FIRST, pick_addr());
        write_reg(REG_REMOTE_IP_SECOND, pick_addr());
    endtask

    task automatic send_run(input int len);
        for (int i = 0; i < len; i++)
            send_word(pick_word(), i == len - 1);
    endtask

    initial
    begin
        int sent;
        int len;

        sb        = new();
        rst_n     = 1'b0;
        cfg_wen   = 1'b0;
        cfg_addr  = REG_HEADER_MODE;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // ---- directed part, reset configuration (no pseudo header) ----
        send_word(16'h0000, 1'b1);           // all-zero data gives 0xFFFF
        send_word(16'hFFFF, 1'b1);
        send_word(16'hFFFF, 1'b0);           // end-around carries
        send_word(16'hFFFF, 1'b0);
        send_word(16'h0001, 1'b1);
        send_word(16'h8000, 1'b0);
        send_word(16'h8000, 1'b1);

        // TCP pseudo header on the reset addresses
        settle();
        write_reg(REG_HEADER_MODE, word_t'(MODE_TCP));
        send_word(16'h1234, 1'b0);
        send_word(16'hABCD, 1'b1);

        // UDP
        settle();
        write_reg(REG_HEADER_MODE, word_t'(MODE_UDP));
        send_word(16'h0000, 1'b1);
        send_word(16'hFFFF, 1'b1);

        // mode three (decodes as TCP), all-ones addresses, junk above mode bits
        settle();
        write_reg(REG_HEADER_MODE, mode_word(MODE_BOTH));
        write_reg(REG_LOCAL_IP_FIRST, '1);
        write_reg(REG_LOCAL_IP_SECOND, '1);
        write_reg(REG_REMOTE_IP_FIRST, '1);
        write_reg(REG_REMOTE_IP_SECOND, '1);
        send_word(16'hFFFF, 1'b1);
        send_word(16'h0000, 1'b0);
        send_word(16'h0000, 1'b1);

        // all-zero addresses, UDP; then writes to unused indexes must do nothing
        settle();
        write_reg(REG_HEADER_MODE, word_t'(MODE_UDP));
        write_reg(REG_LOCAL_IP_FIRST, '0);
        write_reg(REG_LOCAL_IP_SECOND, '0);
        write_reg(REG_REMOTE_IP_FIRST, '0);
        write_reg(REG_REMOTE_IP_SECOND, '0);
        send_word(16'h0001, 1'b1);
        settle();
        for (int i = int'(REG_REMOTE_IP_SECOND) + 1; i < 2 ** INDEX_W; i++)
            write_reg(index_t'(i), word_t'($urandom));
        send_word(16'h5A5A, 1'b1);
        send_word(16'hA5A5, 1'b1);

        // back to no header: all-zero run still gives 0xFFFF
        settle();
        write_reg(REG_HEADER_MODE, mode_word(MODE_NONE));
        send_word(16'h0000, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'h0000, 1'b1);

        // ---- random part: three idling profiles ----
        for (int phase = 0; phase < 3; phase++)
        begin
            reconfigure();
            case (phase)
                0:
                begin
                    tx_idle_pct = 12;
                    rx_idle_pct = 74;
                end
                1:
                begin
                    tx_idle_pct = 74;
                    rx_idle_pct = 12;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase

            if (phase == 2)
            begin
                // receiver holds off while single-word runs keep coming, so
                // both stages fill and the input side stalls
                send_word(pick_word(), 1'b1);
                rx_hold_left = HOLD_CYCLES;
                for (int i = 0; i < 24; i++)
                    send_word(pick_word(), 1'b1);
            end

            sent = 0;
            while (sent < 600)
            begin
                if ($urandom_range(0, 149) == 0)
                    reconfigure();
                else if ($urandom_range(0, 79) == 0)
                    settle();     // sender waits for every checksum
                if ($urandom_range(0, 9) == 0)
                    len = $urandom_range(9, 40);
                else
                    len = $urandom_range(1, 8);
                send_run(len);
                sent += len;
            end
        end

        settle();
        sb.flush_check();

        $display("covered %0d words, %0d checksums, %0d register writes",
                 sb.words_seen, sb.checksums_seen, sb.reg_writes);
        $display("modes none/TCP/UDP/both, address extremes, stall profiles");
        if (sb.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
